### rtl/swm_pkg.sv
// Shared constants, types and state encoding for the sliding-window median filter.
package swm_pkg;

    localparam int VALUE_BITS = 8;
    localparam int WINDOW_MAX = 64;

    localparam int SAMPLE_W   = 8;
    localparam int MEDIAN_W   = 8;
    localparam int CFG_W      = 7;
    localparam int TREE_DEPTH = 1 << VALUE_BITS;
    localparam int IDX_W      = VALUE_BITS + 1;
    localparam int WIN_W      = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int RESET_WIN  = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_DSC_RD,
        ST_DSC_CMP,
        ST_OUT
    } ctrl_state_t;

    // Request from the sequencer to the count tree store.
    typedef struct packed {
        logic                  rd_en;
        logic [VALUE_BITS-1:0] rd_addr;
        logic                  wr_en;
        logic [VALUE_BITS-1:0] wr_addr;
        logic [WIN_W-1:0]      wdata;
    } cmem_req_t;

    // One accepted sample handed from the window bookkeeping to the sequencer.
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] val;
        logic                  full;
        logic                  emit;
        logic [WIN_W-1:0]      need;
    } job_t;

    typedef struct packed {
        logic                  idle;
        ctrl_state_t           state;
        logic [VALUE_BITS-1:0] step;
    } ctrl_status_t;

endpackage

### rtl/swm_count_mem.sv
// Fenwick count tree store with per-entry valid bits; invalid entries read as zero.
module swm_count_mem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       clear,
    input  swm_pkg::cmem_req_t         req,
    output logic [swm_pkg::WIN_W-1:0]  rdata
);
    import swm_pkg::*;

    logic [WIN_W-1:0]      mem [TREE_DEPTH];
    logic [TREE_DEPTH-1:0] valid_reg;
    logic [WIN_W-1:0]      rdata_reg;
    logic                  rvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg  <= mem[req.rd_addr];
            rvalid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

### rtl/swm_delay_mem.sv
// Circular delay line holding the samples of the current window.
module swm_delay_mem (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [swm_pkg::SLOT_W-1:0]      addr,
    input  logic [swm_pkg::VALUE_BITS-1:0]  wdata,
    output logic [swm_pkg::VALUE_BITS-1:0]  rdata
);
    import swm_pkg::*;

    logic [VALUE_BITS-1:0] mem [WINDOW_MAX];
    logic [VALUE_BITS-1:0] rdata_reg;

    // Read returns the oldest sample while the new one overwrites the slot.
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg <= mem[addr];
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/swm_ctrl.sv
// Sequencer: Fenwick remove/add walks and median descent over one shared adder.
module swm_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  swm_pkg::job_t                   job,
    input  logic [swm_pkg::VALUE_BITS-1:0]  old_val,
    output swm_pkg::cmem_req_t              creq,
    input  logic [swm_pkg::WIN_W-1:0]       cdata,
    output swm_pkg::ctrl_status_t           status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [swm_pkg::MEDIAN_W-1:0]    m_tdata
);
    import swm_pkg::*;

    ctrl_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  emit_reg, emit_next;
    logic                  removing_reg, removing_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [VALUE_BITS-1:0] pos_reg, pos_next;
    logic [VALUE_BITS-1:0] step_reg, step_next;
    logic [WIN_W-1:0]      rem_reg, rem_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [MEDIAN_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [IDX_W-1:0]      add_a, add_b, sum;
    logic [IDX_W-1:0]      lowbit;
    logic                  walk_done;

    assign lowbit    = idx_reg & (~idx_reg + IDX_W'(1));
    assign walk_done = (idx_reg == IDX_W'(TREE_DEPTH));

    // Shared adder: tree index step, start index, descent probe position.
    always_comb begin
        add_a = IDX_W'(pos_reg);
        add_b = IDX_W'(step_reg);
        unique case (state_reg)
            ST_IDLE: begin
                add_a = IDX_W'(job.val);
                add_b = IDX_W'(1);
            end
            ST_OLD: begin
                add_a = IDX_W'(old_val);
                add_b = IDX_W'(1);
            end
            ST_UPD_RD, ST_UPD_WR: begin
                if (walk_done) begin
                    add_a = IDX_W'(val_reg);
                    add_b = IDX_W'(1);
                end else begin
                    add_a = idx_reg;
                    add_b = lowbit;
                end
            end
            default: begin
                add_a = IDX_W'(pos_reg);
                add_b = IDX_W'(step_reg);
            end
        endcase
    end

    assign sum = add_a + add_b;

    always_comb begin
        state_next    = state_reg;
        val_next      = val_reg;
        emit_next     = emit_reg;
        removing_next = removing_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        step_next     = step_reg;
        rem_next      = rem_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        creq          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (job.start) begin
                    val_next  = job.val;
                    emit_next = job.emit;
                    rem_next  = job.need;
                    if (job.full) begin
                        removing_next = 1'b1;
                        state_next    = ST_OLD;
                    end else begin
                        removing_next = 1'b0;
                        idx_next      = sum;
                        state_next    = ST_UPD_RD;
                    end
                end
            end
            ST_OLD: begin
                idx_next   = sum;
                state_next = ST_UPD_RD;
            end
            ST_UPD_RD: begin
                creq.rd_en   = 1'b1;
                creq.rd_addr = VALUE_BITS'(idx_reg - IDX_W'(1));
                state_next   = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                creq.wr_en   = 1'b1;
                creq.wr_addr = VALUE_BITS'(idx_reg - IDX_W'(1));
                creq.wdata   = removing_reg ? (cdata - WIN_W'(1)) : (cdata + WIN_W'(1));
                if (!walk_done) begin
                    idx_next   = sum;
                    state_next = ST_UPD_RD;
                end else if (removing_reg) begin
                    // Old sample gone; start counting the new one.
                    removing_next = 1'b0;
                    idx_next      = sum;
                    state_next    = ST_UPD_RD;
                end else if (emit_reg) begin
                    pos_next   = '0;
                    step_next  = VALUE_BITS'(TREE_DEPTH >> 1);
                    state_next = ST_DSC_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DSC_RD: begin
                creq.rd_en   = 1'b1;
                creq.rd_addr = VALUE_BITS'(sum - IDX_W'(1));
                state_next   = ST_DSC_CMP;
            end
            ST_DSC_CMP: begin
                if (cdata < rem_reg) begin
                    pos_next = VALUE_BITS'(sum);
                    rem_next = rem_reg - cdata;
                end
                if (step_reg[0]) begin
                    state_next = ST_OUT;
                end else begin
                    step_next  = step_reg >> 1;
                    state_next = ST_DSC_RD;
                end
            end
            ST_OUT: begin
                // Hold the result until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = MEDIAN_W'(pos_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg      <= val_next;
        emit_reg     <= emit_next;
        removing_reg <= removing_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        step_reg     <= step_next;
        rem_reg      <= rem_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign status.idle  = (state_reg == ST_IDLE);
    assign status.state = state_reg;
    assign status.step  = step_reg;

endmodule

### rtl/sliding_window_median_top.sv
// Top level of the sliding-window lower-median filter.
//
// Usage: one 8-bit unsigned sample enters per s_ transaction. The block keeps
// the last window_size samples (1..64) in a circular delay line and a Fenwick
// count tree over all 256 sample values. Once the window holds window_size
// samples, every sample produces one m_ transaction carrying the lower median;
// while the window fills, samples produce no output.
// Timing: s_tready is high only while the sequencer is idle and no cfg_ write
// is offered. A walk visits 1 to 9 tree nodes, a read and a write each,
// through one count store port and one shared adder: a full window first
// fetches the oldest sample and walks it out, the new sample is walked in,
// then 8 descent probes (read, compare) and an output step follow, after
// which the sequencer returns to idle and can take the next sample.
// The median is held in an output register; when the receiver stalls, the
// next sample may still enter and run until its own result is ready, where
// the sequencer waits for the output register to drain.
// cfg_ (window_size) is taken only while idle and wins over a waiting sample;
// it clamps 0 to 1 and values above 64 to 64, and starts a fresh window.
// Reset: aresetn low, synchronous; window_size returns to 3, window empty.
module sliding_window_median_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tdata: sample [7:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [swm_pkg::SAMPLE_W-1:0]    s_tdata,
    // tdata: median [7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [swm_pkg::MEDIAN_W-1:0]    m_tdata,
    // window_size [6:0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]       cfg_data
);
    import swm_pkg::*;

    logic [WIN_W-1:0]      window_size_reg, window_size_next;
    logic [WIN_W-1:0]      fill_count_reg, fill_count_next;
    logic [SLOT_W-1:0]     write_slot_reg, write_slot_next;

    ctrl_status_t          status;
    job_t                  job;
    cmem_req_t             creq;
    logic [WIN_W-1:0]      cdata;
    logic [VALUE_BITS-1:0] old_val;
    logic [VALUE_BITS-1:0] sample_val;

    logic                  s_accept;
    logic                  cfg_accept;
    logic [SLOT_W-1:0]     slot_cur;
    logic [WIN_W-1:0]      slot_inc;
    logic [WIN_W-1:0]      fill_inc;
    logic [WIN_W:0]        ws_plus;
    logic                  full;
    logic [WIN_W-1:0]      cfg_clamped;

    // Hold off samples while a register write is offered.
    assign s_tready   = status.idle && !cfg_valid;
    assign cfg_ready  = status.idle;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign sample_val = VALUE_BITS'(s_tdata);

    // Wrap the write slot if the window shrank below it.
    assign slot_cur = (WIN_W'(write_slot_reg) >= window_size_reg) ? '0 : write_slot_reg;
    assign slot_inc = WIN_W'(slot_cur) + WIN_W'(1);
    assign fill_inc = fill_count_reg + WIN_W'(1);
    assign full     = (fill_count_reg >= window_size_reg);
    assign ws_plus  = {1'b0, window_size_reg} + (WIN_W + 1)'(1);

    always_comb begin
        if (cfg_data == '0) begin
            cfg_clamped = WIN_W'(1);
        end else if (int'(cfg_data) > WINDOW_MAX) begin
            cfg_clamped = WIN_W'(WINDOW_MAX);
        end else begin
            cfg_clamped = WIN_W'(cfg_data);
        end
    end

    always_comb begin
        window_size_next = window_size_reg;
        fill_count_next  = fill_count_reg;
        write_slot_next  = write_slot_reg;
        if (cfg_accept) begin
            // Start a fresh window.
            window_size_next = cfg_clamped;
            fill_count_next  = '0;
            write_slot_next  = '0;
        end else if (s_accept) begin
            if (!full) begin
                fill_count_next = fill_inc;
            end
            write_slot_next = (slot_inc >= window_size_reg) ? '0 : SLOT_W'(slot_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WIN_W'(RESET_WIN);
            fill_count_reg  <= '0;
            write_slot_reg  <= '0;
        end else begin
            window_size_reg <= window_size_next;
            fill_count_reg  <= fill_count_next;
            write_slot_reg  <= write_slot_next;
        end
    end

    assign job.start = s_accept;
    assign job.val   = sample_val;
    assign job.full  = full;
    assign job.emit  = full || (fill_inc == window_size_reg);
    assign job.need  = WIN_W'(ws_plus >> 1);

    swm_delay_mem u_delay (
        .aclk  (aclk),
        .en    (s_accept),
        .addr  (slot_cur),
        .wdata (sample_val),
        .rdata (old_val)
    );

    swm_count_mem u_counts (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_accept),
        .req     (creq),
        .rdata   (cdata)
    );

    swm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job      (job),
        .old_val  (old_val),
        .creq     (creq),
        .cdata    (cdata),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A new result appears only out of the output state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(status.state == ST_OUT))
        else $error("median transaction raised outside the output state");

    // The window never holds more samples than its size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= window_size_reg)
        else $error("fill count exceeds window size");

    // Descent probes one power-of-two step at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (status.state == ST_DSC_RD || status.state == ST_DSC_CMP) |-> $onehot(status.step))
        else $error("descent step is not a single bit");

    // A sample arriving on a full window must first fetch the oldest sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && full) |=> (status.state == ST_OLD))
        else $error("full-window sample skipped removal of the oldest sample");

endmodule
